// ===== hdl/slc_pkg.sv =====
package slc_pkg;

    // Register indexes on the configuration port.
    localparam logic [1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [1:0] CFG_INDEX_BITS  = 2'd1;
    localparam logic [1:0] CFG_WAY_BITS    = 2'd2;

    // Item kinds.
    localparam logic KIND_ACCESS = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [5:0] OFFSET_BITS_RST = 6'd6;
    localparam logic [3:0] INDEX_BITS_RST  = 4'd4;
    localparam logic [1:0] WAY_BITS_RST    = 2'd2;

    // Current configuration as seen by the front and back parts.
    typedef struct packed {
        logic [5:0] offset_bits;
        logic [3:0] index_bits;
        logic [1:0] way_bits;
    } cfg_t;

endpackage

// ===== hdl/set_assoc_lru_cache_model_top.sv =====
// A taken item waits in the queue while the back part is busy, then passes through cur_reg
// and the lookup state to done_reg. The back part pops no new item until the last is through.
// A two-entry queue takes up to two items ahead; busy is high while it is full.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset (rst_n low, asynchronous) restores the default configuration and empties all sets;
// no clearing pass is needed, so items are taken in the first cycle after reset.
module set_assoc_lru_cache_model_top #(
    parameter int MAX_SETS  = 256,
    parameter int MAX_WAYS  = 8,
    parameter int ADDR_BITS = 48
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 kind,
    input  logic [ADDR_BITS-1:0] address,
    output logic                 done,
    output logic                 hit,
    output logic [31:0]          miss_count,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [5:0]           cfg_data
);
    import slc_pkg::*;

    localparam int SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int ENT_W = 1 + SET_W + ADDR_BITS;

    cfg_t             cfg_reg;
    logic             cfg_write;
    logic             cfg_clear;
    logic [ENT_W-1:0] entry, head;
    logic             q_empty, q_full, q_pop;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign cfg_clear = cfg_write && (cfg_index == CFG_OFFSET_BITS
                       || cfg_index == CFG_INDEX_BITS || cfg_index == CFG_WAY_BITS);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_bits <= OFFSET_BITS_RST;
            cfg_reg.index_bits <= INDEX_BITS_RST;
            cfg_reg.way_bits <= WAY_BITS_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_OFFSET_BITS: cfg_reg.offset_bits <= cfg_data;
                CFG_INDEX_BITS:  cfg_reg.index_bits <= cfg_data[3:0];
                CFG_WAY_BITS:    cfg_reg.way_bits <= cfg_data[1:0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    slc_front #(
        .MAX_SETS  (MAX_SETS),
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .cfg     (cfg_reg),
        .kind    (kind),
        .address (address),
        .entry   (entry)
    );

    slc_queue #(
        .WIDTH (ENT_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (start && !busy),
        .push_data (entry),
        .pop       (q_pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    assign busy = q_full;

    slc_back #(
        .MAX_SETS  (MAX_SETS),
        .MAX_WAYS  (MAX_WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .cfg_clear  (cfg_clear),
        .q_empty    (q_empty),
        .q_head     (head),
        .q_pop      (q_pop),
        .done       (done),
        .hit        (hit),
        .miss_count (miss_count)
    );

endmodule

// ===== hdl/slc_ram.sv =====
module slc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/slc_front.sv =====
module slc_front #(
    parameter int MAX_SETS  = 256,
    parameter int ADDR_BITS = 48,
    parameter int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
    input  slc_pkg::cfg_t          cfg,
    input  logic                   kind,
    input  logic [ADDR_BITS-1:0]   address,
    output logic [SET_W+ADDR_BITS:0] entry
);
    import slc_pkg::*;

    // Largest index width whose set count still fits.
    localparam int SET_LG = $clog2(MAX_SETS + 1) - 1;

    logic [3:0]           ib;
    logic [6:0]           tag_shift;
    logic [ADDR_BITS-1:0] shifted;
    logic [SET_W-1:0]     set_mask;
    logic [SET_W-1:0]     set_idx;
    logic [ADDR_BITS-1:0] tag;

    // Split the address into set index and tag.
    always_comb
    begin
        ib = (cfg.index_bits > 4'(SET_LG)) ? 4'(SET_LG) : cfg.index_bits;
        shifted = address >> cfg.offset_bits;
        set_mask = ~({SET_W{1'b1}} << ib);
        set_idx = shifted[SET_W-1:0] & set_mask;
        tag_shift = {1'b0, cfg.offset_bits} + {3'b000, ib};
        tag = address >> tag_shift;
    end

    assign entry = {kind, set_idx, tag};

endmodule

// ===== hdl/slc_queue.sv =====
module slc_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             empty,
    output logic             full
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head = slot_reg[rd_ptr_reg];
    assign empty = (count_reg == 2'd0);
    assign full = (count_reg == 2'd2);

endmodule

// ===== hdl/slc_back.sv =====
module slc_back #(
    parameter int MAX_SETS  = 256,
    parameter int MAX_WAYS  = 8,
    parameter int ADDR_BITS = 48,
    parameter int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  slc_pkg::cfg_t            cfg,
    input  logic                     cfg_clear,
    input  logic                     q_empty,
    input  logic [SET_W+ADDR_BITS:0] q_head,
    output logic                     q_pop,
    output logic                     done,
    output logic                     hit,
    output logic [31:0]              miss_count
);
    import slc_pkg::*;

    localparam int WAY_LG  = $clog2(MAX_WAYS + 1) - 1;
    localparam int RANK_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int FILL_W  = $clog2(MAX_WAYS + 1);
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int TAGS_W  = MAX_WAYS * ADDR_BITS;
    localparam int RANKS_W = MAX_WAYS * RANK_W;
    localparam int ROW_W   = TAGS_W + RANKS_W + MAX_WAYS + FILL_W;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_LOOKUP = 2'b10
    } state_t;

    state_t                   state_reg, state_next;
    logic [SET_W+ADDR_BITS:0] cur_reg;
    logic [MAX_SETS-1:0]      set_valid_reg;
    logic [31:0]              miss_reg, miss_next;
    logic                     done_reg;
    logic                     hit_reg, hit_next;
    logic [31:0]              count_reg;

    logic                     cur_kind;
    logic [SET_W-1:0]         cur_set;
    logic [ADDR_BITS-1:0]     cur_tag;

    logic [ROW_W-1:0]         rd_row, wr_row;
    logic                     ram_we;

    logic [ADDR_BITS-1:0]     tags   [MAX_WAYS];
    logic [RANK_W-1:0]        ranks  [MAX_WAYS];
    logic [RANK_W-1:0]        nranks [MAX_WAYS];
    logic [MAX_WAYS-1:0]      valid, nvalid, in_use;
    logic [FILL_W-1:0]        fill, nfill;
    logic [FILL_W:0]          ways;
    logic [1:0]               wb;
    logic                     row_live;
    logic                     found;
    logic [WAY_W-1:0]         hit_way, victim;
    logic [RANK_W-1:0]        hit_rank, worst;

    assign cur_kind = cur_reg[SET_W+ADDR_BITS];
    assign cur_set  = cur_reg[SET_W+ADDR_BITS-1:ADDR_BITS];
    assign cur_tag  = cur_reg[ADDR_BITS-1:0];

    slc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_SETS)
    ) u_row_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cur_set),
        .wdata (wr_row),
        .raddr (q_head[SET_W+ADDR_BITS-1:ADDR_BITS]),
        .rdata (rd_row)
    );

    // Unpack the set row; a set not touched since the last clear reads as empty.
    always_comb
    begin
        row_live = set_valid_reg[cur_set];
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            tags[w] = rd_row[w*ADDR_BITS +: ADDR_BITS];
            ranks[w] = row_live ? rd_row[TAGS_W + w*RANK_W +: RANK_W] : '0;
            valid[w] = row_live & rd_row[TAGS_W + RANKS_W + w];
        end
        fill = row_live ? rd_row[ROW_W-1 -: FILL_W] : '0;
    end

    // Tag compare, recency update and victim choice for the current set.
    always_comb
    begin
        wb = (int'(cfg.way_bits) > WAY_LG) ? 2'(WAY_LG) : cfg.way_bits;
        ways = (FILL_W+1)'(1) << wb;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            in_use[w] = ((w >> wb) == 0);
        end

        found = 1'b0;
        hit_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (in_use[w] && valid[w] && tags[w] == cur_tag)
            begin
                found = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
        hit_rank = ranks[hit_way];

        // Least recent way: the last valid way holding the largest rank.
        worst = '0;
        victim = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (in_use[w] && valid[w] && ranks[w] >= worst)
            begin
                worst = ranks[w];
                victim = WAY_W'(w);
            end
        end
        nfill = fill;
        if (!found && {1'b0, fill} < ways)
        begin
            victim = WAY_W'(fill);
            nfill = fill + 1'b1;
        end

        nvalid = valid;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            nranks[w] = ranks[w];
            if (found)
            begin
                if (in_use[w] && valid[w] && ranks[w] < hit_rank)
                begin
                    nranks[w] = ranks[w] + 1'b1;
                end
            end
            else if (in_use[w] && valid[w] && WAY_W'(w) != victim)
            begin
                nranks[w] = ranks[w] + 1'b1;
            end
        end
        if (found)
        begin
            nranks[hit_way] = '0;
        end
        else
        begin
            nranks[victim] = '0;
            nvalid[victim] = 1'b1;
        end

        for (int w = 0; w < MAX_WAYS; w++)
        begin
            wr_row[w*ADDR_BITS +: ADDR_BITS] =
                (!found && WAY_W'(w) == victim) ? cur_tag : tags[w];
            wr_row[TAGS_W + w*RANK_W +: RANK_W] = nranks[w];
            wr_row[TAGS_W + RANKS_W + w] = nvalid[w];
        end
        wr_row[ROW_W-1 -: FILL_W] = nfill;
    end

    // Sequencer: read the set, then write it back (accesses only) and report.
    always_comb
    begin
        state_next = state_reg;
        q_pop = 1'b0;
        ram_we = 1'b0;
        miss_next = miss_reg;
        hit_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_IDLE;
                if (cur_kind == KIND_ACCESS)
                begin
                    ram_we = 1'b1;
                    hit_next = found;
                    if (!found && miss_reg != '1)
                    begin
                        miss_next = miss_reg + 32'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            set_valid_reg <= '0;
            miss_reg <= 32'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= (state_reg == ST_LOOKUP);
            if (cfg_clear || (state_reg == ST_LOOKUP && cur_kind == KIND_FINISH))
            begin
                set_valid_reg <= '0;
                miss_reg <= 32'd0;
            end
            else
            begin
                miss_reg <= miss_next;
                if (ram_we)
                begin
                    set_valid_reg[cur_set] <= 1'b1;
                end
            end
        end
    end

    // Payload registers: the current item and the result beat.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_head;
        end
        if (state_reg == ST_LOOKUP)
        begin
            hit_reg <= hit_next;
            count_reg <= (cur_kind == KIND_FINISH) ? miss_reg : miss_next;
        end
    end

    assign done = done_reg;
    assign hit = hit_reg;
    assign miss_count = count_reg;

endmodule

// ===== hdl/slc_checker.sv =====
module slc_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic cfg_ready
);

    // The back part passes through the idle state between lookups, so beats never abut.
    a_done_spaced: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result beats in consecutive cycles");

    // The queue can only fill after an item was pushed.
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy rose without a start beat");

    // Configuration beats are always taken.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind set_assoc_lru_cache_model_top slc_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .cfg_ready (cfg_ready)
);

// ===== tb/set_assoc_lru_cache_model_top_test.sv =====
module set_assoc_lru_cache_model_top_test;
    import slc_pkg::*;

    localparam int NSETS = 256;
    localparam int NWAYS = 8;
    localparam int ABITS = 48;
    localparam int CYCLE_LIMIT = 400000;

    // Index past the register list; a write there is ignored.
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    logic             kind;
    logic [ABITS-1:0] address;
    logic             done;
    logic             hit;
    logic [31:0]      miss_count;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [1:0]       cfg_index;
    logic [5:0]       cfg_data;

    typedef struct packed {
        logic        hit;
        logic [31:0] miss_count;
    } lookup_t;

    typedef struct {
        logic        kind;
        logic [47:0] address;
        logic        known;
        lookup_t     want;
    } row_t;

    // Shadow copy of the cache tags, ranks and counters.
    logic [5:0]  sh_offset;
    logic [3:0]  sh_index;
    logic [1:0]  sh_ways;
    logic [47:0] sh_tag   [NSETS*NWAYS];
    logic        sh_valid [NSETS*NWAYS];
    logic [2:0]  sh_rank  [NSETS*NWAYS];
    logic [3:0]  sh_fill  [NSETS];
    logic [31:0] sh_misses;

    lookup_t     lookups_due[$];
    int          error_count;
    int          cycle_count;
    int          items_sent;
    int          finishes_sent;
    int          cfg_writes;
    int          results_seen;

    set_assoc_lru_cache_model_top u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .address(address), .done(done), .hit(hit), .miss_count(miss_count),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        error_count++;
    endtask

    function automatic void clear_cache();
        for (int i = 0; i < NSETS*NWAYS; i++)
        begin
            sh_tag[i] = '0;
            sh_valid[i] = 1'b0;
            sh_rank[i] = '0;
        end
        for (int i = 0; i < NSETS; i++)
            sh_fill[i] = '0;
        sh_misses = '0;
    endfunction

    function automatic int clamp_log2(int req, int lim);
        int k;
        k = req;
        while (k > 0 && (1 << k) > lim)
            k--;
        return k;
    endfunction

    // Predict one lookup or finish and update the shadow cache.
    function automatic lookup_t predict_lookup(logic knd, logic [47:0] addr);
        lookup_t r;
        int ib, wb, nw, set, sh, hw, victim, base;
        logic [47:0] tg;
        logic [2:0] rk, worst;
        logic found;
        r = '0;
        if (knd == KIND_FINISH)
        begin
            r.miss_count = sh_misses;
            clear_cache();
            return r;
        end
        ib = clamp_log2(sh_index, NSETS);
        wb = clamp_log2(sh_ways, NWAYS);
        nw = 1 << wb;
        set = (sh_offset < 48) ? int'((addr >> sh_offset) & ((48'd1 << ib) - 1)) : 0;
        sh = sh_offset + ib;
        tg = (sh < 48) ? (addr >> sh) : '0;
        base = set * NWAYS;
        found = 1'b0;
        hw = 0;
        for (int w = 0; w < nw; w++)
            if (!found && sh_valid[base+w] && sh_tag[base+w] == tg)
            begin
                found = 1'b1;
                hw = w;
            end
        if (found)
        begin
            rk = sh_rank[base+hw];
            for (int w = 0; w < nw; w++)
                if (sh_valid[base+w] && sh_rank[base+w] < rk)
                    sh_rank[base+w]++;
            sh_rank[base+hw] = '0;
        end
        else
        begin
            if (sh_misses != 32'hffff_ffff)
                sh_misses++;
            victim = 0;
            if (sh_fill[set] < nw)
            begin
                victim = sh_fill[set];
                sh_fill[set]++;
            end
            else
            begin
                worst = '0;
                for (int w = 0; w < nw; w++)
                    if (sh_valid[base+w] && sh_rank[base+w] >= worst)
                    begin
                        worst = sh_rank[base+w];
                        victim = w;
                    end
            end
            for (int w = 0; w < nw; w++)
                if (w != victim && sh_valid[base+w])
                    sh_rank[base+w]++;
            sh_valid[base+victim] = 1'b1;
            sh_tag[base+victim] = tg;
            sh_rank[base+victim] = '0;
        end
        r.hit = found;
        r.miss_count = sh_misses;
        return r;
    endfunction

    // Cycle counter and timeout.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    // Compare each result beat with the oldest expectation.
    always @(posedge clk)
    begin
        lookup_t e;
        if (rst_n && done)
        begin
            results_seen++;
            if (lookups_due.size() == 0)
                report_mismatch("result beat with nothing expected");
            else
            begin
                e = lookups_due.pop_front();
                if (hit !== e.hit)
                    report_mismatch($sformatf("hit %0b, expected %0b", hit, e.hit));
                if (miss_count !== e.miss_count)
                    report_mismatch($sformatf("miss_count %0d, expected %0d",
                                              miss_count, e.miss_count));
            end
        end
    end

    task automatic wait_drained();
        while (lookups_due.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Send one item; returns after its start beat is taken.
    task automatic send_item(logic knd, logic [47:0] addr, logic known, lookup_t want);
        lookup_t p;
        start <= 1'b1;
        kind <= knd;
        address <= addr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        p = predict_lookup(knd, addr);
        if (known && p != want)
            report_mismatch("predictor disagrees with a fixed table row");
        lookups_due.push_back(known ? want : p);
        items_sent++;
        if (knd == KIND_FINISH)
            finishes_sent++;
    endtask

    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Register write, done only with the block idle.
    task automatic write_reg(logic [1:0] idx, logic [5:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
        if (idx == CFG_OFFSET_BITS)
            sh_offset = val;
        else if (idx == CFG_INDEX_BITS)
            sh_index = val[3:0];
        else if (idx == CFG_WAY_BITS)
            sh_ways = val[1:0];
        if (idx != CFG_UNUSED)
            clear_cache();
    endtask

    function automatic logic [47:0] rand_addr();
        return 48'({$urandom(), $urandom()});
    endfunction

    // Random phase: a small pool of lines so that hits and evictions occur.
    task automatic random_phase(int count);
        logic [47:0] pool [16];
        int burst, np;
        logic [47:0] a;
        logic k;
        np = $urandom_range(3, 16);
        for (int i = 0; i < 16; i++)
            pool[i] = rand_addr();
        burst = 0;
        for (int i = 0; i < count; i++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 20);
                if ($urandom_range(0, 3) != 0)
                    idle_cycles($urandom_range(1, 7));
            end
            burst--;
            k = ($urandom_range(0, 40) == 0) ? KIND_FINISH : KIND_ACCESS;
            if ($urandom_range(0, 4) == 0)
                a = rand_addr();
            else
                a = pool[$urandom_range(0, np-1)] ^ 48'($urandom_range(0, 63));
            send_item(k, a, 1'b0, '0);
        end
        idle_cycles(1);
    endtask

    row_t table_rows [$];

    initial
    begin
        lookup_t w;
        row_t r;
        int dir_count;
        logic [5:0] off_set [5];
        logic [3:0] idx_set [5];
        logic [1:0] way_set [5];

        error_count = 0;
        cycle_count = 0;
        items_sent = 0;
        finishes_sent = 0;
        cfg_writes = 0;
        results_seen = 0;
        rst_n = 1'b0;
        start = 1'b0;
        kind = KIND_ACCESS;
        address = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_OFFSET_BITS;
        cfg_data = '0;
        sh_offset = OFFSET_BITS_RST;
        sh_index = INDEX_BITS_RST;
        sh_ways = WAY_BITS_RST;
        clear_cache();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; fixed expectations only where obvious.
        w = '0;
        r.kind = KIND_FINISH; r.address = '0; r.known = 1'b1; r.want = w;
        table_rows.push_back(r);
        w.hit = 1'b0; w.miss_count = 32'd1;
        r.kind = KIND_ACCESS; r.address = '0; r.known = 1'b1; r.want = w;
        table_rows.push_back(r);
        w.hit = 1'b1; w.miss_count = 32'd1;
        r.address = 48'h3f; r.want = w;
        table_rows.push_back(r);
        w.hit = 1'b0; w.miss_count = 32'd2;
        r.address = 48'hffff_ffff_ffff; r.want = w;
        table_rows.push_back(r);
        r.known = 1'b0;
        // Same set, five tags with four ways: fill then evict the oldest.
        for (int t = 1; t <= 5; t++)
        begin
            r.address = 48'(t) << 10;
            table_rows.push_back(r);
        end
        r.address = 48'h0; table_rows.push_back(r);
        r.address = 48'h400; table_rows.push_back(r);
        r.address = 48'haaaa_aaaa_aaaa; table_rows.push_back(r);
        r.address = 48'h5555_5555_5555; table_rows.push_back(r);
        r.address = 48'h800; table_rows.push_back(r);
        r.kind = KIND_FINISH; r.address = rand_addr(); table_rows.push_back(r);
        w.hit = 1'b0; w.miss_count = 32'd1;
        r.kind = KIND_ACCESS; r.address = 48'h400; r.known = 1'b1; r.want = w;
        table_rows.push_back(r);
        foreach (table_rows[i])
            send_item(table_rows[i].kind, table_rows[i].address,
                      table_rows[i].known, table_rows[i].want);
        idle_cycles(1);
        dir_count = table_rows.size();

        // Pause until every expected result has arrived.
        wait_drained();

        // Settings, extremes included; out-of-range values exercise saturation.
        off_set = '{6'd0, 6'd40, 6'd63, 6'd4, 6'd47};
        idx_set = '{4'd0, 4'd8, 4'd15, 4'd2, 4'd1};
        way_set = '{2'd0, 2'd3, 2'd1, 2'd3, 2'd2};
        for (int s = 0; s < 5; s++)
        begin
            write_reg(CFG_OFFSET_BITS, off_set[s]);
            write_reg(CFG_INDEX_BITS, {2'b00, idx_set[s]});
            write_reg(CFG_WAY_BITS, {4'b0000, way_set[s]});
            if (s == 2)
                write_reg(CFG_UNUSED, 6'h2a);
            random_phase(120);
        end
        write_reg(CFG_OFFSET_BITS, 6'd2);
        write_reg(CFG_INDEX_BITS, 6'd3);
        write_reg(CFG_WAY_BITS, 6'd1);
        random_phase(200);

        wait_drained();
        $display("covered %0d items (%0d directed, %0d finishes), %0d register writes",
                 items_sent, dir_count, finishes_sent, cfg_writes);
        $display("checked %0d result beats, %0d mismatches", results_seen, error_count);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
